FILE: design/scfr_pkg.sv
// shared types and constants for the sync/length/checksum frame receiver
// no dependencies; imported by scfr_step and sum_checksum_frame_receiver
`timescale 1ns / 1ps

package scfr_pkg;

   // input item codes (tuser of the request channel)
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // result kinds (tuser of the response channel)
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT_TICKS     = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD_LEN   = 2'd1;
   localparam logic [1:0] CSR_ERRORS_TO_OFFLINE = 2'd2;

   localparam logic [15:0] TIMEOUT_TICKS_RST     = 16'd300;
   localparam logic [7:0]  MAX_PAYLOAD_LEN_RST   = 8'd120;
   localparam logic [7:0]  ERRORS_TO_OFFLINE_RST = 8'd5;

   localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
   localparam logic [8:0]  HDR_LEN     = 9'd6;
   localparam logic [7:0]  FAIL_MAX    = 8'd255;
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_GOOD         = 2'd0,
      STATUS_BAD_LENGTH   = 2'd1,
      STATUS_BAD_CHECKSUM = 2'd2,
      STATUS_TIMEOUT      = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  max_payload_len;
      logic [7:0]  errors_to_offline;
   } cfg_type;

   typedef struct packed {
      logic        open;
      logic [8:0]  byte_pos;
      logic [7:0]  running_sum;
      logic [7:0]  saved_command;
      logic [7:0]  saved_item;
      logic [7:0]  saved_length;
      logic [15:0] elapsed;
      logic [7:0]  failures;
      logic        reachable;
   } frame_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_pos;
      status_type status;
      logic [7:0] command_code;
      logic [7:0] item_code;
      logic [7:0] length;
      logic [7:0] fail_count;
      logic       online;
   } result_type;

endpackage

FILE: design/scfr_step.sv
// next-state and result logic for one input item of the frame receiver
// depends on scfr_pkg
`timescale 1ns / 1ps

module scfr_step
   import scfr_pkg::*;
(
   input  frame_state_type cur,
   input  cfg_type         cfg,
   input  logic [1:0]      mode,
   input  logic [7:0]      rx_byte,
   output frame_state_type nxt,
   output logic            res_valid,
   output result_type      res
);

   logic        do_verdict;
   status_type  vstatus;
   logic        do_payload;
   logic [8:0]  payload_end;
   logic [8:0]  pos_full;
   logic [7:0]  fail_inc;

   assign payload_end = HDR_LEN + {1'b0, cur.saved_length};
   assign pos_full    = cur.byte_pos - HDR_LEN;
   assign fail_inc    = (cur.failures == FAIL_MAX) ? FAIL_MAX : cur.failures + 8'd1;

   always_comb begin
      nxt        = cur;
      do_verdict = 1'b0;
      vstatus    = STATUS_GOOD;
      do_payload = 1'b0;

      unique case (mode)
         MODE_START: begin
            nxt.open          = 1'b1;
            nxt.byte_pos      = '0;
            nxt.running_sum   = '0;
            nxt.elapsed       = '0;
            nxt.saved_command = '0;
            nxt.saved_item    = '0;
            nxt.saved_length  = '0;
         end
         MODE_TICK: begin
            if (cur.open) begin
               if (cur.elapsed >= cfg.timeout_ticks) begin
                  do_verdict = 1'b1;
                  vstatus    = STATUS_TIMEOUT;
               end else if (cur.elapsed != ELAPSED_MAX) begin
                  nxt.elapsed = cur.elapsed + 16'd1;
               end
            end
         end
         MODE_BYTE: begin
            if (cur.open && !(cur.byte_pos == '0 && rx_byte != SYNC_BYTE)) begin
               if (cur.byte_pos < HDR_LEN) begin
                  // header: sync, two unused bytes, command, item, length
                  nxt.running_sum = cur.running_sum + rx_byte;
                  nxt.byte_pos    = cur.byte_pos + 9'd1;
                  if (cur.byte_pos == 9'd3) nxt.saved_command = rx_byte;
                  if (cur.byte_pos == 9'd4) nxt.saved_item    = rx_byte;
                  if (cur.byte_pos == 9'd5) begin
                     nxt.saved_length = rx_byte;
                     if (rx_byte > cfg.max_payload_len) begin
                        do_verdict = 1'b1;
                        vstatus    = STATUS_BAD_LENGTH;
                     end
                  end
               end else if (cur.byte_pos < payload_end) begin
                  nxt.running_sum = cur.running_sum + rx_byte;
                  nxt.byte_pos    = cur.byte_pos + 9'd1;
                  do_payload      = 1'b1;
               end else begin
                  // checksum byte closes the frame
                  do_verdict = 1'b1;
                  vstatus    = ((8'd0 - cur.running_sum) == rx_byte) ?
                               STATUS_GOOD : STATUS_BAD_CHECKSUM;
               end
            end
         end
         default: ;
      endcase

      if (do_verdict) begin
         nxt.open        = 1'b0;
         nxt.byte_pos    = '0;
         nxt.running_sum = '0;
         if (vstatus == STATUS_GOOD) begin
            nxt.failures  = '0;
            nxt.reachable = 1'b1;
         end else begin
            nxt.failures = fail_inc;
            if (fail_inc >= cfg.errors_to_offline) nxt.reachable = 1'b0;
         end
      end
   end

   always_comb begin
      res_valid        = do_verdict | do_payload;
      res.kind         = do_verdict ? KIND_VERDICT : KIND_PAYLOAD;
      res.payload_byte = do_payload ? rx_byte : 8'd0;
      res.payload_pos  = do_payload ? pos_full[7:0] : 8'd0;
      res.status       = do_verdict ? vstatus : STATUS_GOOD;
      res.command_code = nxt.saved_command;
      res.item_code    = nxt.saved_item;
      res.length       = nxt.saved_length;
      res.fail_count   = nxt.failures;
      res.online       = nxt.reachable;
   end

endmodule

FILE: design/sum_checksum_frame_receiver.sv
// top level of the sync/length/checksum frame receiver: ports, state and result registers
// depends on scfr_pkg and scfr_step
`timescale 1ns / 1ps

// Receiver for a serial request/response link. A start item (req_tuser 2) opens a
// transaction; received bytes (req_tuser 0) are dropped until the 0xAA sync byte,
// which begins a six byte header (byte 3 command, byte 4 item, byte 5 payload
// length). Each payload byte comes out as a kind 0 item with its position; the byte
// after the payload is checked against zero minus the 8-bit sum of all earlier frame
// bytes and yields a kind 1 verdict item. Tick items (req_tuser 1) time out an open
// transaction, and a length above max_payload_len fails the frame when it arrives.
// Each verdict updates a consecutive-failure count (saturating at 255) and the online
// flag. Each item is handled as it is accepted: the frame state registers are updated at
// the accepting edge and any result is loaded into a single output register, so one
// item per cycle is sustained as long as rsp_tready is high; req_tready drops only
// while that output register holds a result the sink has not taken.
// Configuration writes go straight to the registers and are meant for idle periods.

module sum_checksum_frame_receiver
   import scfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [15:8] payload_pos, [17:16] status, [25:18] command_code,
   // [33:26] item_code, [41:34] length, [49:42] fail_count, [50] online, rest zero
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] kind

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type         cfg_ff;
   frame_state_type state_ff;
   frame_state_type state_in;
   logic            res_valid;
   result_type      res;
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   logic            req_accept;

   // output register is free when empty or being drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   scfr_step u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .mode      (req_tuser),
      .rx_byte   (req_tdata),
      .nxt       (state_in),
      .res_valid (res_valid),
      .res       (res)
   );

   // configuration registers, index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks     <= TIMEOUT_TICKS_RST;
         cfg_ff.max_payload_len   <= MAX_PAYLOAD_LEN_RST;
         cfg_ff.errors_to_offline <= ERRORS_TO_OFFLINE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS:     cfg_ff.timeout_ticks     <= csr_wdata;
            CSR_MAX_PAYLOAD_LEN:   cfg_ff.max_payload_len   <= csr_wdata[7:0];
            CSR_ERRORS_TO_OFFLINE: cfg_ff.errors_to_offline <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // frame state advances on every accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_ff.online, rsp_ff.fail_count, rsp_ff.length,
                        rsp_ff.item_code, rsp_ff.command_code, rsp_ff.status,
                        rsp_ff.payload_pos, rsp_ff.payload_byte};

   // a good verdict always reports a clean count and the partner online
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_VERDICT && rsp_ff.status == STATUS_GOOD)
      |-> (rsp_ff.fail_count == 8'd0 && rsp_ff.online))
      else $error("good verdict without cleared failure count");

   // payload items never carry a failure status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_PAYLOAD) |-> (rsp_ff.status == STATUS_GOOD))
      else $error("payload item with nonzero status");

   // a closed transaction holds no partial frame
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.open |-> (state_ff.byte_pos == 9'd0 && state_ff.running_sum == 8'd0))
      else $error("closed transaction with frame progress");

   // a start always leaves a transaction open with no elapsed ticks
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == MODE_START)
      |=> (state_ff.open && state_ff.elapsed == 16'd0))
      else $error("start did not open a fresh transaction");

endmodule

FILE: test/sum_checksum_frame_receiver_tb.sv
// self-checking testbench for sum_checksum_frame_receiver: directed frames, then random traffic
// with idle bursts on both sides; results are predicted in-bench and compared per field
// depends on scfr_pkg and the sum_checksum_frame_receiver rtl
`timescale 1ns / 1ps

module sum_checksum_frame_receiver_tb;
   import scfr_pkg::*;

   // mode code the block must ignore
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // header byte positions within the frame (sync byte is position 0)
   localparam logic [8:0] POS_COMMAND = 9'd3;
   localparam logic [8:0] POS_ITEM    = 9'd4;
   localparam logic [8:0] POS_LENGTH  = 9'd5;

   // limit sits far above the slowest legal run, so this only trips on a hang
   localparam int unsigned LIMIT_CYCLES = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [7:0] payload_byte, [15:8] payload_pos, [17:16] status, [25:18] command_code,
   // [33:26] item_code, [41:34] length, [49:42] fail_count, [50] online, rest zero
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;   // [0] kind
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // mirror of the configuration registers, starting from their reset values
   logic [15:0] cfg_timeout    = TIMEOUT_TICKS_RST;
   logic [7:0]  cfg_max_len    = MAX_PAYLOAD_LEN_RST;
   logic [7:0]  cfg_offline_at = ERRORS_TO_OFFLINE_RST;

   // mirror of the deframer state, all zero after reset
   logic        rx_open     = 1'b0;
   logic [8:0]  rx_pos      = '0;
   logic [7:0]  rx_sum      = '0;
   logic [7:0]  hdr_command = '0;
   logic [7:0]  hdr_item    = '0;
   logic [7:0]  hdr_length  = '0;
   logic [15:0] tick_count  = '0;
   logic [7:0]  fail_run    = '0;
   logic        link_up     = 1'b0;

   result_type  awaited_results[$];
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;

   // traffic shaping knobs, changed by the test tasks
   bit sender_gaps = 1'b1;
   bit sink_stalls = 1'b1;
   int sink_hold_cycles = 0;

   sum_checksum_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hang guard
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // result fields that come from the current header and link state
   function automatic result_type snapshot(input logic k, input logic [7:0] pbyte,
                                           input logic [7:0] ppos, input status_type st);
      result_type r;
      r.kind         = k;
      r.payload_byte = pbyte;
      r.payload_pos  = ppos;
      r.status       = st;
      r.command_code = hdr_command;
      r.item_code    = hdr_item;
      r.length       = hdr_length;
      r.fail_count   = fail_run;
      r.online       = link_up;
      return r;
   endfunction

   // end the open frame with a verdict and update the link health counters
   function automatic result_type close_frame(input status_type st);
      rx_open = 1'b0;
      rx_pos  = '0;
      rx_sum  = '0;
      if (st == STATUS_GOOD) begin
         fail_run = '0;
         link_up  = 1'b1;
      end else begin
         if (fail_run != FAIL_MAX)
            fail_run++;
         if (fail_run >= cfg_offline_at)
            link_up = 1'b0;
      end
      return snapshot(KIND_VERDICT, 8'h00, 8'h00, st);
   endfunction

   // advance the mirrored deframer by one item; returns 1 when the item yields a result
   function automatic bit deframe_item(input logic [1:0] mode, input logic [7:0] b,
                                       output result_type r);
      logic [8:0] offset;
      logic [7:0] total;
      r = '0;
      if (mode == MODE_START) begin
         // a start always opens a fresh transaction, dropping any open one silently
         rx_open     = 1'b1;
         rx_pos      = '0;
         rx_sum      = '0;
         tick_count  = '0;
         hdr_command = '0;
         hdr_item    = '0;
         hdr_length  = '0;
         return 1'b0;
      end
      if (!rx_open || mode == MODE_UNUSED)
         return 1'b0;
      if (mode == MODE_TICK) begin
         if (tick_count >= cfg_timeout) begin
            r = close_frame(STATUS_TIMEOUT);
            return 1'b1;
         end
         if (tick_count != ELAPSED_MAX)
            tick_count++;
         return 1'b0;
      end
      // hunting for sync: anything else is dropped
      if (rx_pos == '0 && b != SYNC_BYTE)
         return 1'b0;
      if (rx_pos < HDR_LEN) begin
         rx_sum += b;
         case (rx_pos)
            POS_COMMAND: hdr_command = b;
            POS_ITEM:    hdr_item    = b;
            POS_LENGTH:  hdr_length  = b;
            default: ;
         endcase
         rx_pos++;
         if (rx_pos == HDR_LEN && hdr_length > cfg_max_len) begin
            r = close_frame(STATUS_BAD_LENGTH);
            return 1'b1;
         end
         return 1'b0;
      end
      if (rx_pos < HDR_LEN + {1'b0, hdr_length}) begin
         offset = rx_pos - HDR_LEN;
         r = snapshot(KIND_PAYLOAD, b, offset[7:0], STATUS_GOOD);
         rx_sum += b;
         rx_pos++;
         return 1'b1;
      end
      // checksum byte: frame sum including it must wrap to zero
      total = rx_sum + b;
      r = close_frame(total == 8'h00 ? STATUS_GOOD : STATUS_BAD_CHECKSUM);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // every accepted result item is compared with the oldest prediction
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, tuser %0h tdata %h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", 8'(rsp_tuser), 8'(want.kind));
            check_field("payload_byte", rsp_tdata[7:0], want.payload_byte);
            check_field("payload_pos", rsp_tdata[15:8], want.payload_pos);
            check_field("status", 8'(rsp_tdata[17:16]), 8'(want.status));
            check_field("command_code", rsp_tdata[25:18], want.command_code);
            check_field("item_code", rsp_tdata[33:26], want.item_code);
            check_field("length", rsp_tdata[41:34], want.length);
            check_field("fail_count", rsp_tdata[49:42], want.fail_count);
            check_field("online", 8'(rsp_tdata[50]), 8'(want.online));
            check_field("tdata padding", 8'(rsp_tdata[55:51]), 8'h00);
         end
      end
   end

   // ------------------------------------------------------------------
   // result sink: random stall bursts, plus a long hold-off on request
   // ------------------------------------------------------------------

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // shared driving tasks; all of them return just after a rising edge
   // ------------------------------------------------------------------

   // offer one item, wait for the handshake, then predict its result
   task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
      result_type r;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= b;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      if (deframe_item(mode, b, r))
         awaited_results = {awaited_results, r};
   endtask

   // stop offering and wait until every predicted result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      // the block registers each result; margin also covers a last item with no result
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_TIMEOUT_TICKS:     cfg_timeout    = value;
         CSR_MAX_PAYLOAD_LEN:   cfg_max_len    = value[7:0];
         CSR_ERRORS_TO_OFFLINE: cfg_offline_at = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // send the bytes of one frame from the sync byte on; cut > 0 stops after that many
   // bytes, noise_pct mixes ticks and ignored items in between the bytes
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] itm, input logic [7:0] len,
                             input bit good_sum, input int cut, input int noise_pct);
      logic [7:0] sum;
      logic [7:0] b;
      int n;
      sum = '0;
      // a rejected length closes the frame at header byte 5; a couple of stray bytes follow
      n = (len > cfg_max_len) ? 8 : 7 + int'(len);
      if (cut > 0 && cut < n)
         n = cut;
      for (int i = 0; i < n; i++) begin
         if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
            send_item($urandom_range(0, 1) ? MODE_TICK : MODE_UNUSED,
                      8'($urandom_range(0, 255)));
         if (i == 0)
            b = SYNC_BYTE;
         else if (i == int'(POS_COMMAND))
            b = cmd;
         else if (i == int'(POS_ITEM))
            b = itm;
         else if (i == int'(POS_LENGTH))
            b = len;
         else if (i == 6 + int'(len)) begin
            b = 8'h00 - sum;
            if (!good_sum)
               b = b + 8'($urandom_range(1, 255));
         end else
            b = 8'($urandom_range(0, 255));
         sum += b;
         send_item(MODE_BYTE, b);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // bytes and ticks with no open transaction, and the unused mode, give nothing
   task automatic test_closed_items();
      send_item(MODE_BYTE, SYNC_BYTE);
      send_item(MODE_TICK, 8'hFF);
      send_item(MODE_UNUSED, 8'h00);
   endtask

   // a junk byte before sync is dropped; header fields at their extremes
   task automatic test_good_frame();
      send_item(MODE_START, 8'h00);
      send_item(MODE_BYTE, 8'h55);
      send_frame(8'h00, 8'hFF, 8'd1, 1'b1, 0, 0);
   endtask

   // restart in the middle of a header, then a length byte above the limit
   task automatic test_restart_and_bad_length();
      send_item(MODE_START, 8'hFF);
      send_item(MODE_BYTE, SYNC_BYTE);
      send_item(MODE_BYTE, 8'h01);
      send_item(MODE_UNUSED, 8'hAA);
      send_item(MODE_START, 8'h5A);
      send_frame(8'hFF, 8'h00, 8'hFF, 1'b1, 6, 0);
   endtask

   // zero timeout fails on the first tick; with 2 the third tick is the one
   task automatic test_timeouts();
      drain_results();
      write_reg(CSR_TIMEOUT_TICKS, 16'd0);
      send_item(MODE_START, 8'h00);
      send_item(MODE_TICK, 8'h00);
      drain_results();
      write_reg(CSR_TIMEOUT_TICKS, 16'd2);
      send_item(MODE_START, 8'h00);
      repeat (3) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
      send_item(MODE_TICK, 8'h00);
   endtask

   // offline threshold of zero: every failure drops the link, a success raises it
   task automatic test_bad_checksum();
      drain_results();
      write_reg(CSR_ERRORS_TO_OFFLINE, 16'd0);
      write_reg(CSR_MAX_PAYLOAD_LEN, 16'd0);
      send_item(MODE_START, 8'h00);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 1'b0, 0, 0);
      send_item(MODE_START, 8'h00);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 1'b1, 0, 0);
      send_item(MODE_START, 8'h00);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 1'b0, 0, 0);
   endtask

   // a long run of timeouts: link drops at 255 failures and the count sticks there
   task automatic test_fail_saturation();
      drain_results();
      write_reg(CSR_TIMEOUT_TICKS, 16'd0);
      write_reg(CSR_ERRORS_TO_OFFLINE, 16'd255);
      send_item(MODE_START, 8'h00);
      send_frame(8'h11, 8'h22, 8'd0, 1'b1, 0, 0);
      repeat (258) begin
         send_item(MODE_START, 8'($urandom_range(0, 255)));
         send_item(MODE_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // sink holds off while the sender keeps offering, so the block must stall its input
   task automatic test_backpressure();
      drain_results();
      write_reg(CSR_MAX_PAYLOAD_LEN, 16'd255);
      write_reg(CSR_TIMEOUT_TICKS, 16'd65535);
      sender_gaps = 1'b0;
      sink_hold_cycles = 300;
      send_item(MODE_START, 8'h00);
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd16, 1'b1, 0, 0);
      // sender stays quiet until the sink has taken everything
      drain_results();
      sender_gaps = 1'b1;
   endtask

   // mostly well-formed frames with random content, plus cut frames and stray items;
   // every phase runs under its own register setting, the first two at the extremes
   task automatic test_random_traffic();
      logic [15:0] t;
      logic [7:0]  m;
      logic [7:0]  o;
      logic [7:0]  len;
      logic [7:0]  junk;
      int unsigned first;
      int pick;
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: begin
               t = 16'd65535;
               m = 8'd255;
               o = 8'd255;
            end
            1: begin
               t = 16'd1;
               m = 8'd0;
               o = 8'd1;
            end
            default: begin
               t = 16'($urandom_range(2, 40));
               m = 8'($urandom_range(0, 24));
               o = 8'($urandom_range(1, 10));
            end
         endcase
         write_reg(CSR_TIMEOUT_TICKS, t);
         write_reg(CSR_MAX_PAYLOAD_LEN, {8'h00, m});
         write_reg(CSR_ERRORS_TO_OFFLINE, {8'h00, o});
         // last phase runs flat out on both sides
         if (phase == 5) begin
            sender_gaps = 1'b0;
            sink_stalls = 1'b0;
         end
         first = items_sent;
         while (items_sent - first < 10) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               send_item(MODE_START, 8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, 2)) begin
                  junk = 8'($urandom_range(0, 255));
                  if (junk == SYNC_BYTE)
                     junk = ~junk;
                  send_item(MODE_BYTE, junk);
               end
               // mostly short payloads, now and then right at or above the limit
               case ($urandom_range(0, 9))
                  0: len = (cfg_max_len != 8'd255) ?
                           cfg_max_len + 8'd1 + 8'($urandom_range(0, 254 - cfg_max_len)) :
                           8'($urandom_range(0, 6));
                  1: len = (cfg_max_len <= 8'd16) ? cfg_max_len : 8'($urandom_range(0, 6));
                  default: len = 8'($urandom_range(0, 6));
               endcase
               send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                          $urandom_range(0, 6) != 0, (pick == 7) ? $urandom_range(1, 12) : 0, 4);
            end else begin
               repeat ($urandom_range(1, 4))
                  send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_BYTE;
      csr_we     = 1'b0;
      csr_index  = CSR_TIMEOUT_TICKS;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_closed_items();
      test_good_frame();
      test_restart_and_bad_length();
      test_timeouts();
      test_bad_checksum();
      test_fail_saturation();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
design/scfr_pkg.sv
design/scfr_step.sv
design/sum_checksum_frame_receiver.sv
test/sum_checksum_frame_receiver_tb.sv
